/* hw/rtl/cardchk_pkg.sv */
`timescale 1ns / 1ps

package cardchk_pkg;

    // Field widths of the input and result words.
    localparam int CARD_W  = 63;
    localparam int BRAND_W = 2;
    localparam int COUNT_W = 5;

    // Binary to decimal conversion: the card number is padded to a
    // multiple of the bits shifted in per cycle.
    localparam int NUM_DIGITS    = 19;
    localparam int DIGIT_W       = 4;
    localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
    localparam int BITS_PER_STEP = 4;
    localparam int SHIFT_W       = ((CARD_W + BITS_PER_STEP - 1) / BITS_PER_STEP)
                                   * BITS_PER_STEP;
    localparam int NUM_STEPS     = SHIFT_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(NUM_STEPS);

    // Luhn sum: digits are added in groups, then the group sums are added.
    localparam int GROUP_SIZE = 4;
    localparam int NUM_GROUPS = (NUM_DIGITS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GROUP_W    = 6;
    localparam int TOTAL_W    = 8;
    localparam int MAX_TENS   = (9 * NUM_DIGITS) / 10;

    // Card lengths and prefixes of the supported brands.
    localparam int VISA_SHORT_LEN = 13;
    localparam int AMEX_LEN       = 15;
    localparam int LONG_LEN       = 16;
    localparam logic [DIGIT_W-1:0] VISA_LEAD     = 4'd4;
    localparam logic [DIGIT_W-1:0] AMEX_LEAD     = 4'd3;
    localparam logic [DIGIT_W-1:0] AMEX_SECOND_A = 4'd4;
    localparam logic [DIGIT_W-1:0] AMEX_SECOND_B = 4'd7;
    localparam logic [DIGIT_W-1:0] MC_LEAD       = 4'd5;
    localparam logic [DIGIT_W-1:0] MC_SECOND_LO  = 4'd1;
    localparam logic [DIGIT_W-1:0] MC_SECOND_HI  = 4'd5;

    // Brand codes of the result word.
    localparam logic [BRAND_W-1:0] BRAND_INVALID    = 2'd0;
    localparam logic [BRAND_W-1:0] BRAND_VISA       = 2'd1;
    localparam logic [BRAND_W-1:0] BRAND_AMEX       = 2'd2;
    localparam logic [BRAND_W-1:0] BRAND_MASTERCARD = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic eval;
        logic publish;
    } cmd_t;

endpackage

/* hw/rtl/cardchk_in_if.sv */
`timescale 1ns / 1ps

interface cardchk_in_if;
    logic                           valid;
    logic                           ready;
    logic [cardchk_pkg::CARD_W-1:0] card_number;

    modport source (output valid, output card_number, input ready);
    modport sink (input valid, input card_number, output ready);
endinterface

/* hw/rtl/cardchk_out_if.sv */
`timescale 1ns / 1ps

interface cardchk_out_if;
    logic                            valid;
    logic                            ready;
    logic [cardchk_pkg::BRAND_W-1:0] brand;
    logic                            luhn_ok;
    logic [cardchk_pkg::COUNT_W-1:0] digit_count;

    modport source (output valid, output brand, output luhn_ok, output digit_count,
                    input ready);
    modport sink (input valid, input brand, input luhn_ok, input digit_count,
                  output ready);
endinterface

/* hw/rtl/cardchk_ctrl.sv */
`timescale 1ns / 1ps

module cardchk_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output cardchk_pkg::cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EVAL,
        ST_RESULT
    } state_t;

    state_t                                  state_reg;
    state_t                                  state_next;
    logic [cardchk_pkg::STEP_CNT_W-1:0]      step_cnt_reg;
    logic [cardchk_pkg::STEP_CNT_W-1:0]      step_cnt_next;
    logic                                    out_valid_reg;
    logic                                    out_valid_next;
    logic                                    accept;
    logic                                    publish;

    // A word is taken only while no number is in conversion.
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // The result register is loaded when it is empty or being emptied.
    assign publish = (state_reg == ST_RESULT) && (!out_valid_reg || out_ready);

    // Commands to the datapath follow the state.
    always_comb
    begin
        cmd.load    = accept;
        cmd.step    = (state_reg == ST_CONV);
        cmd.eval    = (state_reg == ST_EVAL);
        cmd.publish = publish;
    end

    // Next state, step counter and result valid flag.
    always_comb
    begin
        state_next     = state_reg;
        step_cnt_next  = step_cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next    = ST_CONV;
                    step_cnt_next = '0;
                end
            end
            ST_CONV:
            begin
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == cardchk_pkg::STEP_CNT_W'(cardchk_pkg::NUM_STEPS - 1))
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (publish)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hw/rtl/cardchk_dp.sv */
`timescale 1ns / 1ps

module cardchk_dp (
    input  logic                             clk,
    input  cardchk_pkg::cmd_t                cmd,
    input  logic [cardchk_pkg::CARD_W-1:0]   card_number,
    output logic [cardchk_pkg::BRAND_W-1:0]  brand,
    output logic                             luhn_ok,
    output logic [cardchk_pkg::COUNT_W-1:0]  digit_count
);

    logic [cardchk_pkg::SHIFT_W-1:0] bin_reg;
    logic [cardchk_pkg::SHIFT_W-1:0] bin_next;
    logic [cardchk_pkg::BCD_W-1:0]   bcd_reg;
    logic [cardchk_pkg::BCD_W-1:0]   bcd_next;
    logic [cardchk_pkg::GROUP_W-1:0] grp_reg  [cardchk_pkg::NUM_GROUPS];
    logic [cardchk_pkg::GROUP_W-1:0] grp_next [cardchk_pkg::NUM_GROUPS];
    logic [cardchk_pkg::COUNT_W-1:0] count_reg;
    logic [cardchk_pkg::COUNT_W-1:0] count_next;
    logic [cardchk_pkg::BRAND_W-1:0] prefix_reg;
    logic [cardchk_pkg::BRAND_W-1:0] prefix_next;
    logic [cardchk_pkg::TOTAL_W-1:0] total;
    logic                            total_ok;
    logic [cardchk_pkg::BRAND_W-1:0] res_brand_reg;
    logic                            res_luhn_reg;
    logic [cardchk_pkg::COUNT_W-1:0] res_count_reg;

    // Double dabble: four input bits enter the decimal register per cycle.
    // Each digit at five or more gets three added before every shift.
    always_comb
    begin
        bcd_next = bcd_reg;
        bin_next = bin_reg;
        for (int s = 0; s < cardchk_pkg::BITS_PER_STEP; s++)
        begin
            for (int d = 0; d < cardchk_pkg::NUM_DIGITS; d++)
            begin
                if (bcd_next[d*cardchk_pkg::DIGIT_W +: cardchk_pkg::DIGIT_W] >= 4'd5)
                begin
                    bcd_next[d*cardchk_pkg::DIGIT_W +: cardchk_pkg::DIGIT_W] =
                        bcd_next[d*cardchk_pkg::DIGIT_W +: cardchk_pkg::DIGIT_W] + 4'd3;
                end
            end
            bcd_next = {bcd_next[cardchk_pkg::BCD_W-2:0],
                        bin_next[cardchk_pkg::SHIFT_W-1]};
            bin_next = {bin_next[cardchk_pkg::SHIFT_W-2:0], 1'b0};
        end
    end

    // Luhn terms summed in groups of four digits. Digits in odd positions
    // from the right are doubled, and a doubled value above nine drops nine.
    always_comb
    begin
        logic [cardchk_pkg::DIGIT_W-1:0] dig;
        logic [cardchk_pkg::DIGIT_W:0]   term;
        int                              idx;
        dig  = '0;
        term = '0;
        idx  = 0;
        for (int g = 0; g < cardchk_pkg::NUM_GROUPS; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < cardchk_pkg::GROUP_SIZE; k++)
            begin
                idx = g * cardchk_pkg::GROUP_SIZE + k;
                if (idx < cardchk_pkg::NUM_DIGITS)
                begin
                    dig = bcd_reg[idx*cardchk_pkg::DIGIT_W +: cardchk_pkg::DIGIT_W];
                    if ((idx % 2) == 1)
                    begin
                        term = {dig, 1'b0};
                        if (term > 5'd9)
                        begin
                            term = term - 5'd9;
                        end
                    end
                    else
                    begin
                        term = {1'b0, dig};
                    end
                    grp_next[g] = grp_next[g] + cardchk_pkg::GROUP_W'(term);
                end
            end
        end
    end

    // Digit count is the place of the highest nonzero digit, plus one.
    always_comb
    begin
        count_next = '0;
        for (int d = 0; d < cardchk_pkg::NUM_DIGITS; d++)
        begin
            if (bcd_reg[d*cardchk_pkg::DIGIT_W +: cardchk_pkg::DIGIT_W] != '0)
            begin
                count_next = cardchk_pkg::COUNT_W'(d + 1);
            end
        end
    end

    // Brand by length and leading digits, before the Luhn result is known.
    always_comb
    begin
        logic [cardchk_pkg::DIGIT_W-1:0] d12;
        logic [cardchk_pkg::DIGIT_W-1:0] d13;
        logic [cardchk_pkg::DIGIT_W-1:0] d14;
        logic [cardchk_pkg::DIGIT_W-1:0] d15;
        d12 = bcd_reg[12*cardchk_pkg::DIGIT_W +: cardchk_pkg::DIGIT_W];
        d13 = bcd_reg[13*cardchk_pkg::DIGIT_W +: cardchk_pkg::DIGIT_W];
        d14 = bcd_reg[14*cardchk_pkg::DIGIT_W +: cardchk_pkg::DIGIT_W];
        d15 = bcd_reg[15*cardchk_pkg::DIGIT_W +: cardchk_pkg::DIGIT_W];
        prefix_next = cardchk_pkg::BRAND_INVALID;
        if (count_next == cardchk_pkg::COUNT_W'(cardchk_pkg::VISA_SHORT_LEN))
        begin
            if (d12 == cardchk_pkg::VISA_LEAD)
            begin
                prefix_next = cardchk_pkg::BRAND_VISA;
            end
        end
        else if (count_next == cardchk_pkg::COUNT_W'(cardchk_pkg::AMEX_LEN))
        begin
            if (d14 == cardchk_pkg::AMEX_LEAD &&
                (d13 == cardchk_pkg::AMEX_SECOND_A || d13 == cardchk_pkg::AMEX_SECOND_B))
            begin
                prefix_next = cardchk_pkg::BRAND_AMEX;
            end
        end
        else if (count_next == cardchk_pkg::COUNT_W'(cardchk_pkg::LONG_LEN))
        begin
            if (d15 == cardchk_pkg::VISA_LEAD)
            begin
                prefix_next = cardchk_pkg::BRAND_VISA;
            end
            else if (d15 == cardchk_pkg::MC_LEAD && d14 >= cardchk_pkg::MC_SECOND_LO &&
                     d14 <= cardchk_pkg::MC_SECOND_HI)
            begin
                prefix_next = cardchk_pkg::BRAND_MASTERCARD;
            end
        end
    end

    // Final Luhn total and its check against the multiples of ten.
    always_comb
    begin
        total = '0;
        for (int g = 0; g < cardchk_pkg::NUM_GROUPS; g++)
        begin
            total = total + cardchk_pkg::TOTAL_W'(grp_reg[g]);
        end
        total_ok = 1'b0;
        for (int k = 0; k <= cardchk_pkg::MAX_TENS; k++)
        begin
            if (total == cardchk_pkg::TOTAL_W'(k * 10))
            begin
                total_ok = 1'b1;
            end
        end
    end

    // Conversion, evaluation and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg <= cardchk_pkg::SHIFT_W'(card_number);
            bcd_reg <= '0;
        end
        else if (cmd.step)
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
        if (cmd.eval)
        begin
            grp_reg    <= grp_next;
            count_reg  <= count_next;
            prefix_reg <= prefix_next;
        end
        if (cmd.publish)
        begin
            res_brand_reg <= total_ok ? prefix_reg : cardchk_pkg::BRAND_INVALID;
            res_luhn_reg  <= total_ok;
            res_count_reg <= count_reg;
        end
    end

    assign brand       = res_brand_reg;
    assign luhn_ok     = res_luhn_reg;
    assign digit_count = res_count_reg;

endmodule

/* hw/rtl/card_number_luhn_brand_check.sv */
`timescale 1ns / 1ps

// Card number checker. Each word on the card channel carries a card number
// as a binary integer; the block answers with one word on the result channel
// giving the decimal digit count, the Luhn mod-10 result and the brand
// (Visa, Amex, Mastercard, or invalid when the Luhn check fails or no brand
// fits the length and prefix). After acceptance a number passes the binary
// to decimal converter, which shifts in four bits per cycle, then the Luhn
// group sums, the digit count and the prefix are registered, and then the
// groups are added and the result register is loaded. The next number is
// taken once the result register is loaded, even while that result waits
// for the sink. A stalled result holds the block only when the next number
// is finished before the previous result has been taken.
module card_number_luhn_brand_check (
    input  logic            clk,
    input  logic            rst_n,
    cardchk_in_if.sink      card,
    cardchk_out_if.source   result
);

    cardchk_pkg::cmd_t cmd;

    cardchk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (card.valid),
        .in_ready  (card.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    cardchk_dp u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .card_number (card.card_number),
        .brand       (result.brand),
        .luhn_ok     (result.luhn_ok),
        .digit_count (result.digit_count)
    );

    // The converter is busy right after a number is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        card.valid && card.ready |=> !card.ready)
        else $error("card channel ready while a number is in conversion");

    // A branded result has passed the Luhn check and has a brand length.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.brand != cardchk_pkg::BRAND_INVALID |->
        result.luhn_ok &&
        (result.digit_count == cardchk_pkg::COUNT_W'(cardchk_pkg::VISA_SHORT_LEN) ||
         result.digit_count == cardchk_pkg::COUNT_W'(cardchk_pkg::AMEX_LEN) ||
         result.digit_count == cardchk_pkg::COUNT_W'(cardchk_pkg::LONG_LEN)))
        else $error("brand given without Luhn pass or at a wrong length");

    // A result word loaded by the datapath is then shown as valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> result.valid)
        else $error("result loaded but not shown as valid");

    // The digit count never exceeds the width of the decimal register.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.digit_count <=
        cardchk_pkg::COUNT_W'(cardchk_pkg::NUM_DIGITS))
        else $error("digit count beyond the converter width");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 40;
    localparam int CARD_W      = cardchk_pkg::CARD_W;
    localparam int COUNT_W     = cardchk_pkg::COUNT_W;
    localparam int VISA_LEAD   = int'(cardchk_pkg::VISA_LEAD);
    localparam int AMEX_LO     = int'(cardchk_pkg::AMEX_LEAD) * 10
                                 + int'(cardchk_pkg::AMEX_SECOND_A);
    localparam int AMEX_HI     = int'(cardchk_pkg::AMEX_LEAD) * 10
                                 + int'(cardchk_pkg::AMEX_SECOND_B);
    localparam int MC_LO       = int'(cardchk_pkg::MC_LEAD) * 10
                                 + int'(cardchk_pkg::MC_SECOND_LO);
    localparam int MC_HI       = int'(cardchk_pkg::MC_LEAD) * 10
                                 + int'(cardchk_pkg::MC_SECOND_HI);

    typedef struct packed {
        logic [cardchk_pkg::BRAND_W-1:0] brand;
        logic                            luhn_ok;
        logic [COUNT_W-1:0]              digit_count;
    } card_verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cardchk_in_if  card_if ();
    cardchk_out_if result_if ();

    card_number_luhn_brand_check u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .card   (card_if),
        .result (result_if)
    );

    card_verdict_t verdict_queue[$];
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_idle_pct = 0;
    int unsigned   mismatches = 0;
    int unsigned   cards_sent = 0;
    int unsigned   verdicts_seen = 0;
    int unsigned   brand_hits[4] = '{0, 0, 0, 0};
    int unsigned   cycle_count = 0;

    always #2 clk = ~clk;

    // Expected verdict for one card number: digit count, Luhn sum and brand.
    function automatic card_verdict_t predict_verdict(input logic [CARD_W-1:0] num);
        card_verdict_t     v;
        logic [CARD_W-1:0] rest;
        int unsigned       digit;
        int unsigned       pos;
        int unsigned       sum;
        int unsigned       top_one;
        int unsigned       top_two;
        rest = num;
        pos = 0;
        sum = 0;
        top_one = 0;
        top_two = 0;
        while (rest != '0)
        begin
            digit = 32'(rest % CARD_W'(10));
            if (rest < CARD_W'(10))
            begin
                top_one = 32'(rest);
            end
            else if (rest < CARD_W'(100))
            begin
                top_two = 32'(rest);
            end
            // Every second digit from the right is doubled, then folded.
            if (pos % 2 == 1)
            begin
                sum += (digit * 2 > 9) ? digit * 2 - 9 : digit * 2;
            end
            else
            begin
                sum += digit;
            end
            rest = rest / CARD_W'(10);
            pos++;
        end
        v.luhn_ok = (sum % 10 == 0);
        v.digit_count = COUNT_W'(pos);
        v.brand = cardchk_pkg::BRAND_INVALID;
        if (v.luhn_ok)
        begin
            if (pos == cardchk_pkg::VISA_SHORT_LEN && top_one == VISA_LEAD)
            begin
                v.brand = cardchk_pkg::BRAND_VISA;
            end
            else if (pos == cardchk_pkg::AMEX_LEN && (top_two == AMEX_LO || top_two == AMEX_HI))
            begin
                v.brand = cardchk_pkg::BRAND_AMEX;
            end
            else if (pos == cardchk_pkg::LONG_LEN)
            begin
                if (top_one == VISA_LEAD)
                begin
                    v.brand = cardchk_pkg::BRAND_VISA;
                end
                else if (top_two >= MC_LO && top_two <= MC_HI)
                begin
                    v.brand = cardchk_pkg::BRAND_MASTERCARD;
                end
            end
        end
        return v;
    endfunction

    // Builds a number of len digits (2 to 18) starting with lead, random in the
    // middle, with a check digit that either passes or fails the Luhn test.
    function automatic logic [CARD_W-1:0] build_card(input int unsigned len,
                                                     input int unsigned lead,
                                                     input bit good_check);
        logic [CARD_W-1:0] num;
        logic [CARD_W-1:0] candidate;
        card_verdict_t     v;
        int unsigned       lead_len;
        int unsigned       pick;
        lead_len = (lead >= 10) ? 2 : 1;
        num = CARD_W'(lead);
        for (int unsigned i = lead_len; i < len - 1; i++)
        begin
            num = num * CARD_W'(10) + CARD_W'($urandom_range(9));
        end
        num = num * CARD_W'(10);
        pick = $urandom_range(9);
        for (int unsigned i = 0; i < 10; i++)
        begin
            candidate = num + CARD_W'((pick + i) % 10);
            v = predict_verdict(candidate);
            if (v.luhn_ok == good_check)
            begin
                return candidate;
            end
        end
        return num;
    endfunction

    // One well-formed card of a random brand shape.
    function automatic logic [CARD_W-1:0] random_brand_card(input bit good_check);
        case ($urandom_range(3))
            0: return build_card(cardchk_pkg::VISA_SHORT_LEN, VISA_LEAD, good_check);
            1: return build_card(cardchk_pkg::LONG_LEN, VISA_LEAD, good_check);
            2: return build_card(cardchk_pkg::AMEX_LEN,
                                 ($urandom_range(1) != 0) ? AMEX_HI : AMEX_LO, good_check);
            default: return build_card(cardchk_pkg::LONG_LEN,
                                       $urandom_range(MC_HI, MC_LO), good_check);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("ERROR: word %0d %s: got %0d, expected %0d",
                 verdicts_seen, what, got, want);
        mismatches++;
    endtask

    // Sends one card number, idling at random first; valid stays high after
    // acceptance so back-to-back words need no second assignment.
    task automatic send_card(input logic [CARD_W-1:0] num);
        while ($urandom_range(99) < send_idle_pct)
        begin
            card_if.valid <= 1'b0;
            @(posedge clk);
        end
        card_if.valid <= 1'b1;
        card_if.card_number <= num;
        do @(posedge clk); while (!card_if.ready);
        verdict_queue.push_back(predict_verdict(num));
        cards_sent++;
    endtask

    task automatic wait_for_verdicts();
        while (verdict_queue.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Receiver: random stalls, and each accepted word checked against the oldest
    // expectation.
    always @(posedge clk)
    begin : verdict_check
        card_verdict_t want;
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (verdict_queue.size() == 0)
                begin
                    report_mismatch("with nothing outstanding, brand", result_if.brand, 0);
                end
                else
                begin
                    want = verdict_queue.pop_front();
                    brand_hits[want.brand]++;
                    if (result_if.brand !== want.brand)
                    begin
                        report_mismatch("brand", result_if.brand, want.brand);
                    end
                    if (result_if.luhn_ok !== want.luhn_ok)
                    begin
                        report_mismatch("luhn_ok", result_if.luhn_ok, want.luhn_ok);
                    end
                    if (result_if.digit_count !== want.digit_count)
                    begin
                        report_mismatch("digit_count", result_if.digit_count,
                                        want.digit_count);
                    end
                end
                verdicts_seen++;
            end
            result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d words outstanding",
                     cycle_count, verdict_queue.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Zero, one- and two-digit values, the largest 63-bit value and a 19-digit power of ten.
    task automatic test_edge_values();
        send_card('0);
        send_card(CARD_W'(1));
        send_card(CARD_W'(9));
        send_card(CARD_W'(10));
        send_card(CARD_W'(59));
        send_card({CARD_W{1'b1}});
        send_card(63'd1000000000000000000);
    endtask

    // A passing card of every brand shape, both Amex prefixes and the lowest and highest Mastercard prefix.
    task automatic test_brands();
        send_card(build_card(cardchk_pkg::VISA_SHORT_LEN, VISA_LEAD, 1'b1));
        send_card(build_card(cardchk_pkg::LONG_LEN, VISA_LEAD, 1'b1));
        send_card(build_card(cardchk_pkg::AMEX_LEN, AMEX_LO, 1'b1));
        send_card(build_card(cardchk_pkg::AMEX_LEN, AMEX_HI, 1'b1));
        send_card(build_card(cardchk_pkg::LONG_LEN, MC_LO, 1'b1));
        send_card(build_card(cardchk_pkg::LONG_LEN, MC_HI, 1'b1));
    endtask

    // Failed Luhn checks and lengths or prefixes that fit no brand.
    task automatic test_invalid_cards();
        send_card(build_card(cardchk_pkg::LONG_LEN, VISA_LEAD, 1'b0));
        send_card(build_card(cardchk_pkg::AMEX_LEN, AMEX_HI, 1'b0));
        send_card(build_card(cardchk_pkg::LONG_LEN, 56, 1'b1));
        send_card(build_card(cardchk_pkg::LONG_LEN, 50, 1'b1));
        send_card(build_card(cardchk_pkg::AMEX_LEN, 35, 1'b1));
        send_card(build_card(cardchk_pkg::LONG_LEN, AMEX_LO, 1'b1));
        send_card(build_card(14, VISA_LEAD, 1'b1));
        send_card(build_card(cardchk_pkg::AMEX_LEN, VISA_LEAD, 1'b1));
        send_card(build_card(12, VISA_LEAD, 1'b1));
        send_card(build_card(17, 52, 1'b1));
    endtask

    // Mostly well-formed cards, with broken check digits, odd shapes and raw bits.
    task automatic test_random_cards(input int unsigned count);
        int unsigned       kind;
        int unsigned       len;
        logic [63:0]       raw;
        logic [CARD_W-1:0] num;
        for (int unsigned n = 0; n < count; n++)
        begin
            kind = $urandom_range(99);
            if (kind < 50)
            begin
                num = random_brand_card(1'b1);
            end
            else if (kind < 65)
            begin
                num = random_brand_card(1'b0);
            end
            else if (kind < 80)
            begin
                len = $urandom_range(18, 2);
                num = build_card(len, (len >= 3) ? $urandom_range(99, 10) : $urandom_range(9, 1),
                                 ($urandom_range(1) != 0));
            end
            else
            begin
                raw = {$urandom, $urandom};
                num = raw[CARD_W-1:0] >> $urandom_range(CARD_W - 1, 0);
            end
            send_card(num);
        end
    endtask

    // After eight cards the sender holds off until every outstanding verdict has arrived, then sends eight more.
    task automatic test_drain_pause();
        for (int n = 0; n < 8; n++)
        begin
            send_card(random_brand_card(1'b1));
        end
        card_if.valid <= 1'b0;
        wait_for_verdicts();
        for (int n = 0; n < 8; n++)
        begin
            send_card(random_brand_card($urandom_range(1) != 0));
        end
    endtask

    initial
    begin
        card_if.valid = 1'b0;
        card_if.card_number = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 29;
        recv_idle_pct = 57;
        test_edge_values();
        test_brands();
        test_invalid_cards();
        test_drain_pause();
        test_random_cards(667);

        send_idle_pct = 57;
        recv_idle_pct = 29;
        test_random_cards(667);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_cards(667);

        card_if.valid <= 1'b0;
        wait_for_verdicts();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (verdict_queue.size() != 0)
        begin
            report_mismatch("verdicts never returned", verdict_queue.size(), 0);
        end

        $display("Checked %0d card numbers under three stall mixes: %0d visa, %0d amex,",
                 cards_sent, brand_hits[cardchk_pkg::BRAND_VISA],
                 brand_hits[cardchk_pkg::BRAND_AMEX]);
        $display("%0d mastercard and %0d invalid verdicts, %0d field errors",
                 brand_hits[cardchk_pkg::BRAND_MASTERCARD],
                 brand_hits[cardchk_pkg::BRAND_INVALID], mismatches);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/cardchk_pkg.sv
hw/rtl/cardchk_in_if.sv
hw/rtl/cardchk_out_if.sv
hw/rtl/cardchk_ctrl.sv
hw/rtl/cardchk_dp.sv
hw/rtl/card_number_luhn_brand_check.sv
sim/tb.sv
